### design/crcu_pkg.sv
`timescale 1ns / 1ps

package crcu_pkg;

    // Word store size and configuration port geometry.
    localparam int STORE_WORDS_DEFAULT = 1024;
    localparam int PADDR_W = 2;
    localparam logic [PADDR_W-1:0] REG_BASE_WORD_ADDR = 2'd0;

    // CRC-16/CCITT-FALSE constants.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_HDR       = 3'd0,
        ST_HDR_OK    = 3'd1,
        ST_DATA      = 3'd2,
        ST_DONE_OK   = 3'd3,
        ST_ZERO      = 3'd4,
        ST_UNALIGNED = 3'd5,
        ST_TOO_LARGE = 3'd6,
        ST_CRC_ERR   = 3'd7
    } status_t;

    // Frame phase: four header bytes, then payload.
    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_HDR2    = 3'd2,
        PH_HDR3    = 3'd3,
        PH_PAYLOAD = 3'd4
    } phase_t;

    // One result item as produced by the frame core.
    typedef struct packed {
        status_t     status;
        logic        word_valid;
        logic [31:0] data_word;
        logic [9:0]  word_addr;
        logic [15:0] crc_now;
    } result_t;

    // Advance the CRC by one byte, MSB first, unrolled into XOR logic.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### design/crcu_cfg.sv
`timescale 1ns / 1ps

module crcu_cfg
    import crcu_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic [9:0]         base_word_addr
);

    logic [9:0] base_reg;
    logic       wr_en;

    // The register is written in the access phase of a write.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == REG_BASE_WORD_ADDR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else if (wr_en)
        begin
            base_reg <= pwdata[9:0];
        end
    end

    // Read back; unmapped addresses read as zero.
    assign prdata = (paddr == REG_BASE_WORD_ADDR) ? {22'd0, base_reg} : 32'd0;

    assign base_word_addr = base_reg;

endmodule

### design/crcu_core.sv
`timescale 1ns / 1ps

module crcu_core
    import crcu_pkg::*;
#(
    parameter int STORE_WORDS = STORE_WORDS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] rx_byte,
    input  logic [9:0] base_word_addr,
    output result_t    result
);

    localparam logic [15:0] STORE_LIMIT = 16'(STORE_WORDS);

    phase_t      phase_reg, phase_next;
    logic [15:0] byte_total_reg, byte_total_next;
    logic [15:0] crc_expected_reg, crc_expected_next;
    logic [15:0] crc_running_reg, crc_running_next;
    logic [15:0] bytes_seen_reg, bytes_seen_next;
    logic [23:0] word_assembly_reg, word_assembly_next;

    logic [15:0] crc_new;
    logic [15:0] seen_inc;
    logic [15:0] fit_sum;

    assign crc_new  = crc_byte(crc_running_reg, rx_byte);
    assign seen_inc = bytes_seen_reg + 16'd1;
    assign fit_sum  = {6'd0, base_word_addr} + {2'd0, byte_total_reg[15:2]};

    // Frame state registers, advanced once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HDR0;
            byte_total_reg    <= '0;
            crc_expected_reg  <= '0;
            crc_running_reg   <= CRC_INIT;
            bytes_seen_reg    <= '0;
            word_assembly_reg <= '0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            byte_total_reg    <= byte_total_next;
            crc_expected_reg  <= crc_expected_next;
            crc_running_reg   <= crc_running_next;
            bytes_seen_reg    <= bytes_seen_next;
            word_assembly_reg <= word_assembly_next;
        end
    end

    // Next state and result for the byte being processed.
    always_comb
    begin
        phase_next         = phase_reg;
        byte_total_next    = byte_total_reg;
        crc_expected_next  = crc_expected_reg;
        crc_running_next   = crc_running_reg;
        bytes_seen_next    = bytes_seen_reg;
        word_assembly_next = word_assembly_reg;

        result.status     = ST_HDR;
        result.word_valid = 1'b0;
        result.data_word  = '0;
        result.word_addr  = '0;
        result.crc_now    = crc_running_reg;

        unique case (phase_reg)
            PH_HDR0:
            begin
                byte_total_next = {8'h00, rx_byte};
                phase_next      = PH_HDR1;
            end
            PH_HDR1:
            begin
                byte_total_next = {rx_byte, byte_total_reg[7:0]};
                phase_next      = PH_HDR2;
            end
            PH_HDR2:
            begin
                crc_expected_next = {8'h00, rx_byte};
                phase_next        = PH_HDR3;
            end
            PH_HDR3:
            begin
                crc_expected_next  = {rx_byte, crc_expected_reg[7:0]};
                phase_next         = PH_HDR0;
                bytes_seen_next    = '0;
                word_assembly_next = '0;
                crc_running_next   = CRC_INIT;
                // Header checks in order: zero size, alignment, store bounds.
                priority if (byte_total_reg == 16'd0)
                begin
                    result.status = ST_ZERO;
                end
                else if (byte_total_reg[1:0] != 2'b00)
                begin
                    result.status = ST_UNALIGNED;
                end
                else if (fit_sum > STORE_LIMIT)
                begin
                    result.status = ST_TOO_LARGE;
                end
                else
                begin
                    result.status = ST_HDR_OK;
                    phase_next    = PH_PAYLOAD;
                end
                result.crc_now = CRC_INIT;
            end
            PH_PAYLOAD:
            begin
                result.crc_now   = crc_new;
                crc_running_next = crc_new;
                bytes_seen_next  = seen_inc;

                // Pack bytes little-endian; the fourth byte completes a word.
                unique case (bytes_seen_reg[1:0])
                    2'd0:    word_assembly_next = {16'd0, rx_byte};
                    2'd1:    word_assembly_next = {8'd0, rx_byte, word_assembly_reg[7:0]};
                    2'd2:    word_assembly_next = {rx_byte, word_assembly_reg[15:0]};
                    default:
                    begin
                        word_assembly_next = '0;
                        result.word_valid  = 1'b1;
                        result.data_word   = {rx_byte, word_assembly_reg};
                        result.word_addr   = base_word_addr + bytes_seen_reg[11:2];
                    end
                endcase

                // Last payload byte closes the frame.
                if (seen_inc >= byte_total_reg)
                begin
                    result.status      = (crc_new == crc_expected_reg) ? ST_DONE_OK : ST_CRC_ERR;
                    phase_next         = PH_HDR0;
                    bytes_seen_next    = '0;
                    word_assembly_next = '0;
                    crc_running_next   = CRC_INIT;
                end
                else
                begin
                    result.status = ST_DATA;
                end
            end
            default:
            begin
                phase_next         = PH_HDR0;
                bytes_seen_next    = '0;
                word_assembly_next = '0;
                crc_running_next   = CRC_INIT;
            end
        endcase
    end

endmodule

### design/crc_checked_upload_receiver.sv
`timescale 1ns / 1ps
// Length-prefixed upload receiver with a CRC-16/CCITT-FALSE check.
// Input channel: one received byte per item on rx_byte (in_valid/in_ready).
// Each frame is a 4-byte header (byte count, expected CRC, both little-endian)
// followed by the payload. Output channel (out_valid/out_ready): one result
// item per input byte with status, an optional completed 32-bit word and its
// store address, and the running CRC. Words are only safe to commit once the
// frame reports done ok.
// Configuration: base_word_addr at APB address 0. The user is to write it
// only while idle; the block itself does not enforce this. An accepted byte
// is held in the input register, then its result item is registered.
// Throughput: one byte per cycle while out_ready is high; the per-byte CRC is
// an unrolled XOR network between the input register and the result register.
// Stalls: while out_ready is low the result is held; one more byte can still
// be taken into the input register, after which in_ready drops.
// Reset: both registers empty, the receiver waits for a header, the base
// address is zero and the running CRC is 0xFFFF.

module crc_checked_upload_receiver
    import crcu_pkg::*;
#(
    parameter int STORE_WORDS = STORE_WORDS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic               word_valid,
    output logic [31:0]        data_word,
    output logic [9:0]         word_addr,
    output logic [15:0]        crc_now
);

    logic [9:0] base_word_addr;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    result_reg;
    result_t    core_result;
    logic       advance;

    crcu_cfg u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .base_word_addr (base_word_addr)
    );

    // A byte moves into the result register when there is room for it.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    crcu_core #(
        .STORE_WORDS (STORE_WORDS)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .rx_byte        (in_byte_reg),
        .base_word_addr (base_word_addr),
        .result         (core_result)
    );

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = result_reg.status;
    assign word_valid = result_reg.word_valid;
    assign data_word  = result_reg.data_word;
    assign word_addr  = result_reg.word_addr;
    assign crc_now    = result_reg.crc_now;

    // A completed word only comes with a payload status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && word_valid) |->
            (status == ST_DATA || status == ST_DONE_OK || status == ST_CRC_ERR))
        else $error("word reported outside payload");

    // Without a completed word the word fields read as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !word_valid) |-> (data_word == 32'd0 && word_addr == 10'd0))
        else $error("stale word fields");

    // Header results always carry the initial CRC.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_HDR || status == ST_HDR_OK || status == ST_ZERO ||
                       status == ST_UNALIGNED || status == ST_TOO_LARGE))
            |-> (crc_now == CRC_INIT))
        else $error("header result with running CRC");

    // Input stalls only when a byte is held and the result side is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && out_valid && !out_ready))
        else $error("input stalled without cause");

endmodule
